// ----- hdl/nopr_pkg.sv -----
package nopr_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned GAIN_W = 48;
    localparam int unsigned PEAK_W = 63;

    localparam logic [WORD_W-1:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [WORD_W-1:0] SMIN = 64'h8000_0000_0000_0001;

    typedef enum logic [2:0] {
        REG_DISP_TO_ACC = 3'd0,
        REG_DISP_TO_VEL = 3'd1,
        REG_VEL_TO_ACC  = 3'd2,
        REG_DAMPING     = 3'd3,
        REG_INV_STIFF   = 3'd4,
        REG_SPARE5      = 3'd5,
        REG_SPARE6      = 3'd6,
        REG_SPARE7      = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic              go;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] b;
        logic              sh56;
        logic              full;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] res;
    } t_mul_rsp;

endpackage

// ----- hdl/nopr_mul.sv -----
module nopr_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  nopr_pkg::t_mul_req i_req,
    output nopr_pkg::t_mul_rsp o_rsp
);

    localparam logic [2:0] CNT_FIN = 3'd5;

    logic                r_busy;
    logic [2:0]          r_cnt;
    logic                r_neg;
    logic                r_sh56;
    logic                r_full;
    logic [63:0]         r_ma;
    logic [63:0]         r_mb;
    logic [63:0]         r_pp;
    logic [1:0]          r_pp_sh;
    logic                r_pp_v;
    logic [127:0]        r_acc;
    logic                r_done;
    logic [63:0]         r_res;

    logic [31:0]         w_ah;
    logic [31:0]         w_bh;
    logic [63:0]         w_pp;
    logic [127:0]        w_add;
    logic [63:0]         w_rl;
    logic                w_rh_nz;
    logic                w_over;
    logic [63:0]         w_mag;

    assign w_ah = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
    assign w_bh = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
    assign w_pp = w_ah * w_bh;

    always_comb begin
        case (r_pp_sh)
            2'd0:    w_add = {64'd0, r_pp};
            2'd1:    w_add = {32'd0, r_pp, 32'd0};
            default: w_add = {r_pp, 64'd0};
        endcase
    end

    // round bit is preloaded into the accumulator, here only shift and clamp
    assign w_rl    = r_sh56 ? r_acc[119:56] : r_acc[87:24];
    assign w_rh_nz = r_sh56 ? (|r_acc[127:120]) : (|r_acc[127:88]);
    assign w_over  = w_rh_nz || (!r_full && w_rl[63]);
    assign w_mag   = w_over ? (r_full ? {64{1'b1}} : nopr_pkg::SMAX) : w_rl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
            r_pp_v <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_pp_v <= r_busy && !r_cnt[2];
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == CNT_FIN) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_done <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_neg  <= i_req.x[63];
            r_ma   <= i_req.x[63] ? (-i_req.x) : i_req.x;
            r_mb   <= i_req.b;
            r_sh56 <= i_req.sh56;
            r_full <= i_req.full;
            r_acc  <= i_req.sh56 ? (128'd1 << 55) : (128'd1 << 23);
        end else if (r_pp_v) begin
            r_acc <= r_acc + w_add;
        end
        r_pp    <= w_pp;
        r_pp_sh <= {1'b0, r_cnt[0]} + {1'b0, r_cnt[1]};
        if (r_busy && r_cnt == CNT_FIN) begin
            r_res <= r_neg ? (-w_mag) : w_mag;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

// ----- hdl/newmark_oscillator_peak_response.sv -----
// Peak response of a damped single-degree oscillator to ground acceleration, integrated
// with Newmark-beta average acceleration. A sample flagged in tuser starts a record:
// it clears state and peaks without using the multiplier. Every other sample runs seven
// 64x64 products through one shared 32x32 multiplier, four partial products each,
// plus saturating adds, and holds tready low until its state update is written.
// After a sample with tlast, an emit state presents the three peaks; the output
// register lets the next sample start while the peaks wait. Gains must be written
// through the configuration channel while no sample is in flight; nothing enforces it.
module newmark_oscillator_peak_response (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [47:0]    i_cfg_data,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [31:0]    s_axis_tdata,  // ground_accel[31:0]
    input  logic           s_axis_tlast,
    input  logic [0:0]     s_axis_tuser,  // first_sample[0]
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // peak_total_accel[62:0], peak_velocity[125:63], peak_displacement[188:126], zero
    output logic [191:0]   m_axis_tdata
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CP   = 4'd1;
    localparam logic [3:0] ST_M1   = 4'd2;
    localparam logic [3:0] ST_M2   = 4'd3;
    localparam logic [3:0] ST_PA   = 4'd4;
    localparam logic [3:0] ST_UNGO = 4'd5;
    localparam logic [3:0] ST_UN   = 4'd6;
    localparam logic [3:0] ST_DU   = 4'd7;
    localparam logic [3:0] ST_M3GO = 4'd8;
    localparam logic [3:0] ST_M3   = 4'd9;
    localparam logic [3:0] ST_M5   = 4'd10;
    localparam logic [3:0] ST_M4   = 4'd11;
    localparam logic [3:0] ST_AN   = 4'd12;
    localparam logic [3:0] ST_UPD  = 4'd13;
    localparam logic [3:0] ST_EMIT = 4'd14;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (!s[64] && s[63]) begin
            return nopr_pkg::SMAX;
        end else if (s[64] && (!s[63] || s[62:0] == 63'd0)) begin
            return nopr_pkg::SMIN;
        end else begin
            return s[63:0];
        end
    endfunction

    function automatic logic [62:0] abs_val(input logic [63:0] a);
        logic [63:0] m;
        m = a[63] ? (-a) : a;
        return m[62:0];
    endfunction

    logic [47:0]  r_p1;
    logic [47:0]  r_p2;
    logic [47:0]  r_p3;
    logic [47:0]  r_c;
    logic [47:0]  r_k;

    logic [3:0]   r_state;
    logic [3:0]   n_state;
    logic         r_last;
    logic [63:0]  r_g;
    logic [63:0]  r_u;
    logic [63:0]  r_v;
    logic [63:0]  r_a;
    logic [62:0]  r_max_acc;
    logic [62:0]  r_max_vel;
    logic [62:0]  r_max_disp;
    logic [63:0]  r_p;
    logic [63:0]  r_t;
    logic [63:0]  r_du;
    logic [63:0]  r_vn;
    logic [63:0]  r_m5;
    logic [63:0]  r_an;
    logic         r_ovalid;
    logic [188:0] r_out;

    nopr_pkg::t_mul_req w_req;
    nopr_pkg::t_mul_rsp w_rsp;

    logic         w_in_acc;
    logic         w_emit;
    logic [63:0]  w_g;
    logic [64:0]  w_a1_sum;
    logic [63:0]  w_a1;
    logic [63:0]  w_a2;
    logic [63:0]  w_add_x;
    logic [63:0]  w_add_y;
    logic         w_add_neg;
    logic [63:0]  w_sum;
    logic [62:0]  w_abs_u;
    logic [62:0]  w_abs_v;
    logic [62:0]  w_abs_t;

    nopr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_emit        = (r_state == ST_EMIT) && (!r_ovalid || m_axis_tready);

    assign w_g      = {{8{s_axis_tdata[31]}}, s_axis_tdata, 24'd0};
    assign w_a1_sum = {17'd0, r_p1} + {1'b0, w_rsp.res};
    assign w_a1     = w_a1_sum[64] ? {64{1'b1}} : w_a1_sum[63:0];
    assign w_a2     = {16'd0, r_p3} + {16'd0, r_c};

    always_comb begin
        w_req      = '0;
        w_req.x    = r_u;
        unique case (r_state)
            ST_IDLE: begin
                w_req.go   = w_in_acc && !s_axis_tuser[0];
                w_req.x    = {16'd0, r_p2};
                w_req.b    = {16'd0, r_c};
                w_req.full = 1'b1;
            end
            ST_CP: begin
                w_req.go = w_rsp.done;
                w_req.x  = r_u;
                w_req.b  = w_a1;
            end
            ST_M1: begin
                w_req.go = w_rsp.done;
                w_req.x  = r_v;
                w_req.b  = w_a2;
            end
            ST_UNGO: begin
                w_req.go   = 1'b1;
                w_req.x    = r_p;
                w_req.b    = {16'd0, r_k};
                w_req.sh56 = 1'b1;
            end
            ST_M3GO: begin
                w_req.go = 1'b1;
                w_req.x  = r_du;
                w_req.b  = {16'd0, r_p2};
            end
            ST_M3: begin
                w_req.go = w_rsp.done;
                w_req.x  = r_v;
                w_req.b  = {16'd0, r_p3};
            end
            ST_M5: begin
                w_req.go = w_rsp.done;
                w_req.x  = r_du;
                w_req.b  = {16'd0, r_p1};
            end
            default: begin
                w_req.go = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_add_x   = r_p;
        w_add_y   = w_rsp.res;
        w_add_neg = 1'b0;
        case (r_state)
            ST_PA: begin
                w_add_y = r_a;
            end
            ST_DU: begin
                w_add_x   = r_t;
                w_add_y   = r_u;
                w_add_neg = 1'b1;
            end
            ST_M3: begin
                w_add_x   = w_rsp.res;
                w_add_y   = r_v;
                w_add_neg = 1'b1;
            end
            ST_M4: begin
                w_add_x   = w_rsp.res;
                w_add_y   = r_m5;
                w_add_neg = 1'b1;
            end
            ST_AN: begin
                w_add_x   = r_an;
                w_add_y   = r_a;
                w_add_neg = 1'b1;
            end
            ST_UPD: begin
                w_add_x = r_an;
                w_add_y = r_g;
            end
            default: begin
                w_add_x = r_p;
            end
        endcase
    end

    assign w_sum   = sat_add(w_add_x, w_add_neg ? (-w_add_y) : w_add_y);
    assign w_abs_u = abs_val(r_t);
    assign w_abs_v = abs_val(r_vn);
    assign w_abs_t = abs_val(w_sum);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (!s_axis_tuser[0]) begin
                        n_state = ST_CP;
                    end else if (s_axis_tlast) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_CP:   if (w_rsp.done) n_state = ST_M1;
            ST_M1:   if (w_rsp.done) n_state = ST_M2;
            ST_M2:   if (w_rsp.done) n_state = ST_PA;
            ST_PA:   n_state = ST_UNGO;
            ST_UNGO: n_state = ST_UN;
            ST_UN:   if (w_rsp.done) n_state = ST_DU;
            ST_DU:   n_state = ST_M3GO;
            ST_M3GO: n_state = ST_M3;
            ST_M3:   if (w_rsp.done) n_state = ST_M5;
            ST_M5:   if (w_rsp.done) n_state = ST_M4;
            ST_M4:   if (w_rsp.done) n_state = ST_AN;
            ST_AN:   n_state = ST_UPD;
            ST_UPD:  n_state = r_last ? ST_EMIT : ST_IDLE;
            ST_EMIT: if (w_emit) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1       <= 48'd671088640000;
            r_p2       <= 48'd3355443200;
            r_p3       <= 48'd6710886400;
            r_c        <= 48'd10541026;
            r_k        <= 48'd1794000000000;
            r_state    <= ST_IDLE;
            r_ovalid   <= 1'b0;
            r_u        <= '0;
            r_v        <= '0;
            r_a        <= '0;
            r_max_acc  <= '0;
            r_max_vel  <= '0;
            r_max_disp <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    nopr_pkg::REG_DISP_TO_ACC: r_p1 <= i_cfg_data;
                    nopr_pkg::REG_DISP_TO_VEL: r_p2 <= i_cfg_data;
                    nopr_pkg::REG_VEL_TO_ACC:  r_p3 <= i_cfg_data;
                    nopr_pkg::REG_DAMPING:     r_c  <= i_cfg_data;
                    nopr_pkg::REG_INV_STIFF:   r_k  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == ST_IDLE && w_in_acc && s_axis_tuser[0]) begin
                r_u        <= '0;
                r_v        <= '0;
                r_a        <= -w_g;
                r_max_acc  <= '0;
                r_max_vel  <= '0;
                r_max_disp <= '0;
            end
            if (r_state == ST_UPD) begin
                r_u <= r_t;
                r_v <= r_vn;
                r_a <= r_an;
                if (w_abs_u > r_max_disp) r_max_disp <= w_abs_u;
                if (w_abs_v > r_max_vel)  r_max_vel  <= w_abs_v;
                if (w_abs_t > r_max_acc)  r_max_acc  <= w_abs_t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_in_acc) begin
            r_g    <= w_g;
            r_p    <= -w_g;
            r_last <= s_axis_tlast;
        end
        if ((r_state == ST_M1 || r_state == ST_M2) && w_rsp.done) r_p <= w_sum;
        if (r_state == ST_PA) r_p <= w_sum;
        if (r_state == ST_UN && w_rsp.done) r_t <= w_rsp.res;
        if (r_state == ST_DU) r_du <= w_sum;
        if (r_state == ST_M3 && w_rsp.done) r_vn <= w_sum;
        if (r_state == ST_M5 && w_rsp.done) r_m5 <= w_rsp.res;
        if ((r_state == ST_M4 && w_rsp.done) || r_state == ST_AN) r_an <= w_sum;
        if (w_emit) r_out <= {r_max_disp, r_max_vel, r_max_acc};
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'd0, r_out};

endmodule

// ----- hdl/nopr_check.sv -----
module nopr_check (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [0:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [191:0] m_axis_tdata
);

    // an ordinary sample occupies the integrator
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0]) |=> !s_axis_tready)
        else $error("ready returned right after an ordinary sample");

    // an ordinary sample cannot produce a result on the next cycle
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0]) |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[191:189] == 3'd0))
        else $error("padding bits not zero");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind newmark_oscillator_peak_response nopr_check u_nopr_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
